@@ hw/rtl/d2q9_pkg.sv @@
// ----------------------------------------------------------------------------
// d2q9 collision package
// Shared widths, lattice tables, register codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package d2q9_pkg;

    localparam int FRAC_BITS = 28;
    localparam int DATA_W    = 32;
    localparam int NDIR      = 9;
    localparam int SUM_W     = DATA_W + 4;
    localparam int MAG_W     = DATA_W + 3;
    localparam int Q_BITS    = DATA_W - 1;
    localparam int DIV_LAT   = Q_BITS + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int CMP_W     = MAG_W + FRAC_BITS + DATA_W;
    localparam int LANE_LAT  = 6;
    localparam int PIPE_LEN  = 2 + DIV_LAT + 1 + LANE_LAT + 1;
    localparam int SAT_W     = 80;
    localparam int T2_W      = DATA_W + 2;
    localparam int SQ_W      = 2 * DATA_W - FRAC_BITS;
    localparam int POLY_W    = SQ_W + 6;
    localparam int RP_W      = 2 * DATA_W;
    localparam int RECIP_SH  = 35;
    localparam int PR_W      = DATA_W + 33;

    localparam int RATE_W    = 30;
    localparam int REFD_W    = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RELAX_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DENSITY = 1'd1;

    localparam logic [RATE_W-1:0] RELAX_RATE_RST  = RATE_W'(1) << FRAC_BITS;
    localparam logic [REFD_W-1:0] REF_DENSITY_RST = REFD_W'(1) << FRAC_BITS;

    // round(2^35 / 9)
    localparam logic [32:0] RECIP9 = 33'd3817748708;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef data_t pop_t [NDIR];

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        W_REST,
        W_AXIS,
        W_DIAG
    } wclass_t;

    localparam logic signed [1:0] DIR_X [NDIR] =
        '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] DIR_Y [NDIR] =
        '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam wclass_t WCLASS [NDIR] =
        '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS, W_DIAG, W_DIAG, W_DIAG, W_DIAG};

    typedef struct packed {
        logic signed [DATA_W-1:0] q;
        logic [3:0]               r;
    } div9_t;

    function automatic data_t sat_data(input logic signed [SAT_W-1:0] x);
        data_t y;
        if (x > SAT_W'(DATA_MAX))
            y = DATA_MAX;
        else if (x < SAT_W'(DATA_MIN))
            y = DATA_MIN;
        else
            y = DATA_W'(x);
        return y;
    endfunction

    // fix a reciprocal estimate of floor(y / 9) that is off by at most one
    function automatic div9_t div9_fix(input data_t y, input data_t q_est);
        logic signed [DATA_W+4:0] r_raw;
        div9_t d;
        r_raw = (DATA_W+5)'(y)
              - (((DATA_W+5)'(q_est) <<< 3) + (DATA_W+5)'(q_est));
        if (r_raw < 0)
        begin
            d.q = q_est - DATA_W'(1);
            d.r = 4'(r_raw + 9);
        end
        else if (r_raw >= 9)
        begin
            d.q = q_est + DATA_W'(1);
            d.r = 4'(r_raw - 9);
        end
        else
        begin
            d.q = q_est;
            d.r = 4'(r_raw);
        end
        return d;
    endfunction

    // floor(4 r / 9) for a remainder below nine
    function automatic logic [1:0] frac49(input logic [3:0] r);
        logic [1:0] y;
        case (r) inside
            [4'd0:4'd2]: y = 2'd0;
            [4'd3:4'd4]: y = 2'd1;
            [4'd5:4'd6]: y = 2'd2;
            default:     y = 2'd3;
        endcase
        return y;
    endfunction

endpackage

@@ hw/rtl/d2q9_if.sv @@
// ----------------------------------------------------------------------------
// d2q9 channel interfaces
// Node input channel and collision result channel, valid/ready.
// ----------------------------------------------------------------------------
interface d2q9_node_if;
    import d2q9_pkg::*;

    logic  valid;
    logic  ready;
    data_t f_rest;
    data_t f_east;
    data_t f_north;
    data_t f_west;
    data_t f_south;
    data_t f_northeast;
    data_t f_northwest;
    data_t f_southwest;
    data_t f_southeast;
    logic  is_solid;

    modport source (
        output valid, f_rest, f_east, f_north, f_west, f_south,
               f_northeast, f_northwest, f_southwest, f_southeast, is_solid,
        input  ready
    );
    modport sink (
        input  valid, f_rest, f_east, f_north, f_west, f_south,
               f_northeast, f_northwest, f_southwest, f_southeast, is_solid,
        output ready
    );
endinterface

interface d2q9_res_if;
    import d2q9_pkg::*;

    logic  valid;
    logic  ready;
    data_t out_rest;
    data_t out_east;
    data_t out_north;
    data_t out_west;
    data_t out_south;
    data_t out_northeast;
    data_t out_northwest;
    data_t out_southwest;
    data_t out_southeast;
    data_t density;
    data_t vel_x;
    data_t vel_y;

    modport source (
        output valid, out_rest, out_east, out_north, out_west, out_south,
               out_northeast, out_northwest, out_southwest, out_southeast,
               density, vel_x, vel_y,
        input  ready
    );
    modport sink (
        input  valid, out_rest, out_east, out_north, out_west, out_south,
               out_northeast, out_northwest, out_southwest, out_southeast,
               density, vel_x, vel_y,
        output ready
    );
endinterface

@@ hw/rtl/d2q9_div.sv @@
// ----------------------------------------------------------------------------
// d2q9 velocity divider
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module d2q9_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [d2q9_pkg::SUM_W-1:0] num,
    input  logic signed [d2q9_pkg::DATA_W-1:0] den,
    output logic signed [d2q9_pkg::DATA_W-1:0] quo
);
    import d2q9_pkg::*;

    logic [MAG_W-1:0]  mag;
    logic [DVD_W-1:0]  dvd;
    logic [Q_BITS-1:0] den_mag;
    logic              neg;
    logic              zero;
    logic              ovf;

    logic [Q_BITS-1:0] rem_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg    [Q_BITS+1];
    logic [Q_BITS-1:0] low_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] den_reg  [Q_BITS+1];
    logic              neg_reg  [Q_BITS+1];
    logic              ovf_reg  [Q_BITS+1];
    logic              zero_reg [Q_BITS+1];

    assign neg     = num[SUM_W-1];
    assign mag     = neg ? MAG_W'(-num) : MAG_W'(num);
    assign den_mag = den[Q_BITS-1:0];
    assign zero    = den[DATA_W-1] || (den == '0);
    assign dvd     = DVD_W'(mag) << FRAC_BITS;
    assign ovf     = (CMP_W'(mag) << FRAC_BITS) >= (CMP_W'(den_mag) << Q_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= Q_BITS'(dvd >> Q_BITS);
            q_reg[0]    <= '0;
            low_reg[0]  <= dvd[Q_BITS-1:0];
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= neg;
            ovf_reg[0]  <= ovf;
            zero_reg[0] <= zero;
        end
    end

    for (genvar s = 1; s <= Q_BITS; s++)
    begin : g_step
        logic [Q_BITS:0]   trial;
        logic              ge;
        logic [Q_BITS-1:0] rem_next;

        assign trial    = {rem_reg[s-1], low_reg[s-1][Q_BITS-s]};
        assign ge       = trial >= {1'b0, den_reg[s-1]};
        assign rem_next = ge ? Q_BITS'(trial - {1'b0, den_reg[s-1]}) : Q_BITS'(trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= {q_reg[s-1][Q_BITS-2:0], ge};
                low_reg[s]  <= low_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[Q_BITS])
            quo = '0;
        else if (ovf_reg[Q_BITS])
            quo = neg_reg[Q_BITS] ? DATA_MIN : DATA_MAX;
        else if (neg_reg[Q_BITS])
            quo = -$signed({1'b0, q_reg[Q_BITS]});
        else
            quo = $signed({1'b0, q_reg[Q_BITS]});
    end

endmodule

@@ hw/rtl/d2q9_lane.sv @@
// ----------------------------------------------------------------------------
// d2q9 direction lane
// Equilibrium and BGK relaxation for one lattice direction, six stages.
// ----------------------------------------------------------------------------
module d2q9_lane (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [1:0]                 cx,
    input  logic signed [1:0]                 cy,
    input  logic signed [d2q9_pkg::DATA_W-1:0] u,
    input  logic signed [d2q9_pkg::DATA_W-1:0] v,
    input  logic signed [d2q9_pkg::DATA_W-1:0] f_in,
    input  logic signed [d2q9_pkg::DATA_W-1:0] rw,
    input  logic signed [d2q9_pkg::DATA_W-1:0] t1,
    input  logic [d2q9_pkg::RATE_W-1:0]        omega,
    output logic signed [d2q9_pkg::DATA_W-1:0] lane_out,
    output logic signed [d2q9_pkg::DATA_W-1:0] f_out
);
    import d2q9_pkg::*;

    logic signed [T2_W-1:0]     xu;
    logic signed [T2_W-1:0]     yv;
    logic [DATA_W-1:0]          m;
    logic [2*DATA_W-1:0]        msq;
    logic signed [POLY_W-1:0]   p_t2;
    logic signed [POLY_W-1:0]   p_sq;
    logic signed [POLY_W-1:0]   p_t1;
    logic signed [POLY_W-1:0]   poly_sum;
    logic signed [2*DATA_W-1:0] prod_next;
    data_t                      feq;
    logic signed [DATA_W:0]     diff_next;
    logic signed [RP_W-1:0]     rp_next;

    data_t                      t2_reg;
    data_t                      t2b_reg;
    logic [SQ_W-1:0]            sq_reg;
    data_t                      rw2_reg;
    data_t                      rw3_reg;
    data_t                      poly_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W:0]     diff_reg;
    logic signed [RP_W-1:0]     rp_reg;
    data_t                      f_reg [LANE_LAT];

    always_comb
    begin
        if (cx == 2'sd1)
            xu = T2_W'(u);
        else if (cx == -2'sd1)
            xu = -T2_W'(u);
        else
            xu = '0;
        if (cy == 2'sd1)
            yv = T2_W'(v);
        else if (cy == -2'sd1)
            yv = -T2_W'(v);
        else
            yv = '0;
    end

    assign m   = t2_reg[DATA_W-1] ? DATA_W'(-t2_reg) : DATA_W'(t2_reg);
    assign msq = m * m;

    assign p_t2     = POLY_W'(t2b_reg);
    assign p_sq     = POLY_W'(sq_reg);
    assign p_t1     = POLY_W'(t1);
    assign poly_sum = (POLY_W'(1) <<< FRAC_BITS) + p_t2 + (p_t2 <<< 1)
                    + (((p_sq <<< 3) + p_sq) >>> 1)
                    - ((p_t1 + (p_t1 <<< 1)) >>> 1);

    assign prod_next = rw3_reg * poly_reg;
    assign feq       = sat_data(SAT_W'(prod_reg >>> FRAC_BITS));
    assign diff_next = (DATA_W+1)'(feq) - (DATA_W+1)'(f_reg[3]);
    assign rp_next   = $signed({1'b0, omega}) * diff_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg   <= sat_data(SAT_W'(xu + yv));
            t2b_reg  <= t2_reg;
            sq_reg   <= SQ_W'(msq >> FRAC_BITS);
            rw2_reg  <= rw;
            rw3_reg  <= rw2_reg;
            poly_reg <= sat_data(SAT_W'(poly_sum));
            prod_reg <= prod_next;
            diff_reg <= diff_next;
            rp_reg   <= rp_next;
            f_reg[0] <= f_in;
            for (int i = 1; i < LANE_LAT; i++)
                f_reg[i] <= f_reg[i-1];
        end
    end

    assign lane_out = sat_data(SAT_W'(f_reg[LANE_LAT-1]) + SAT_W'(rp_reg >>> FRAC_BITS));
    assign f_out    = f_reg[LANE_LAT-1];

endmodule

@@ hw/rtl/d2q9_bgk_collision.sv @@
// ----------------------------------------------------------------------------
// d2q9 BGK collision
// Moment recovery, velocity division, nine parallel relaxation lanes and a
// result merge stage for one D2Q9 lattice node per transfer.
// ----------------------------------------------------------------------------
// throughput: one node per cycle, the whole pipeline stalls while a result waits
// latency is mostly set by the 31-stage bit-per-stage velocity divider
// reset clears all stage valids; relax_rate and ref_density return to 1.0
// ----------------------------------------------------------------------------
module d2q9_bgk_collision (
    input  logic                               clk,
    input  logic                               rst_n,
    d2q9_node_if.sink                          node,
    d2q9_res_if.source                         res,
    input  logic                               cfg_wr_en,
    input  logic [d2q9_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [d2q9_pkg::CFG_W-1:0]         cfg_wr_data
);
    import d2q9_pkg::*;

    logic                  en;
    logic [PIPE_LEN-1:0]   vld_reg;
    logic [RATE_W-1:0]     relax_rate_reg;
    logic [REFD_W-1:0]     ref_density_reg;

    pop_t                  node_pop;
    pop_t                  fa_reg;
    logic                  sa_reg;
    logic signed [SUM_W-1:0] sum_next, jx_next, jy_next;
    logic signed [SUM_W-1:0] sum_reg, jx_reg, jy_reg;
    pop_t                  fb_reg;
    logic                  sb_reg;
    data_t                 rho_b;

    data_t                 qx, qy;
    data_t                 fd_reg   [DIV_LAT][NDIR];
    data_t                 rhod_reg [DIV_LAT];
    logic                  sd_reg   [DIV_LAT];

    data_t                 rho_d;
    data_t                 rho_q;
    pop_t                  f1_reg;
    data_t                 u1_reg, v1_reg, rho1_reg, rq1_reg;
    logic                  s1_reg;
    logic signed [PR_W-1:0] pr9_reg, pr36_reg;

    div9_t                 d9, d36;
    logic signed [DATA_W+2:0] w49;
    logic [DATA_W-1:0]     uu, vv;
    data_t                 rw49_reg, rw19_reg, rw136_reg;
    logic [2*DATA_W-1:0]   uu2_reg, vv2_reg;
    logic [2*DATA_W:0]     usum;
    data_t                 t1_reg;

    data_t                 rhop_reg [LANE_LAT];
    data_t                 up_reg   [LANE_LAT];
    data_t                 vp_reg   [LANE_LAT];
    logic                  sp_reg   [LANE_LAT];

    pop_t                  rw_lane;
    pop_t                  lane_res;
    pop_t                  lane_f;
    pop_t                  out_reg;
    data_t                 dens_reg, vx_reg, vy_reg;

    assign en         = !vld_reg[PIPE_LEN-1] || res.ready;
    assign node.ready = en;
    assign res.valid  = vld_reg[PIPE_LEN-1];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg  <= RELAX_RATE_RST;
            ref_density_reg <= REF_DENSITY_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RELAX_RATE:  relax_rate_reg  <= cfg_wr_data[RATE_W-1:0];
                REG_REF_DENSITY: ref_density_reg <= cfg_wr_data[REFD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LEN-2:0], node.valid};
    end

    assign node_pop[0] = node.f_rest;
    assign node_pop[1] = node.f_east;
    assign node_pop[2] = node.f_north;
    assign node_pop[3] = node.f_west;
    assign node_pop[4] = node.f_south;
    assign node_pop[5] = node.f_northeast;
    assign node_pop[6] = node.f_northwest;
    assign node_pop[7] = node.f_southwest;
    assign node_pop[8] = node.f_southeast;

    // moments
    always_comb
    begin
        sum_next = '0;
        jx_next  = '0;
        jy_next  = '0;
        for (int k = 0; k < NDIR; k++)
        begin
            sum_next = sum_next + SUM_W'(fa_reg[k]);
            if (DIR_X[k] == 2'sd1)
                jx_next = jx_next + SUM_W'(fa_reg[k]);
            else if (DIR_X[k] == -2'sd1)
                jx_next = jx_next - SUM_W'(fa_reg[k]);
            if (DIR_Y[k] == 2'sd1)
                jy_next = jy_next + SUM_W'(fa_reg[k]);
            else if (DIR_Y[k] == -2'sd1)
                jy_next = jy_next - SUM_W'(fa_reg[k]);
        end
    end

    assign rho_b = sat_data(SAT_W'(sum_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg  <= node_pop;
            sa_reg  <= node.is_solid;
            fb_reg  <= fa_reg;
            sb_reg  <= sa_reg;
            sum_reg <= sum_next;
            jx_reg  <= jx_next;
            jy_reg  <= jy_next;
        end
    end

    d2q9_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (jx_reg),
        .den (rho_b),
        .quo (qx)
    );

    d2q9_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (jy_reg),
        .den (rho_b),
        .quo (qy)
    );

    // node data alongside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fd_reg[0]   <= fb_reg;
            rhod_reg[0] <= rho_b;
            sd_reg[0]   <= sb_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                fd_reg[i]   <= fd_reg[i-1];
                rhod_reg[i] <= rhod_reg[i-1];
                sd_reg[i]   <= sd_reg[i-1];
            end
        end
    end

    assign rho_d = rhod_reg[DIV_LAT-1];
    assign rho_q = rho_d >>> 2;

    // weighted density: reciprocal estimate, then correction
    assign d9  = div9_fix(rho1_reg, DATA_W'(pr9_reg >>> RECIP_SH));
    assign d36 = div9_fix(rq1_reg, DATA_W'(pr36_reg >>> RECIP_SH));
    assign w49 = ((DATA_W+3)'(d9.q) <<< 2) + (DATA_W+3)'(frac49(d9.r));

    assign uu   = u1_reg[DATA_W-1] ? DATA_W'(-u1_reg) : DATA_W'(u1_reg);
    assign vv   = v1_reg[DATA_W-1] ? DATA_W'(-v1_reg) : DATA_W'(v1_reg);
    assign usum = (2*DATA_W+1)'(uu2_reg) + (2*DATA_W+1)'(vv2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg    <= fd_reg[DIV_LAT-1];
            u1_reg    <= qx;
            v1_reg    <= qy;
            rho1_reg  <= rho_d;
            rq1_reg   <= rho_q;
            s1_reg    <= sd_reg[DIV_LAT-1];
            pr9_reg   <= rho_d * $signed(RECIP9);
            pr36_reg  <= rho_q * $signed(RECIP9);
            rw19_reg  <= d9.q;
            rw136_reg <= d36.q;
            rw49_reg  <= sat_data(SAT_W'(w49));
            uu2_reg   <= uu * uu;
            vv2_reg   <= vv * vv;
            t1_reg    <= sat_data(SAT_W'(usum >> FRAC_BITS));
            rhop_reg[0] <= rho1_reg;
            up_reg[0]   <= u1_reg;
            vp_reg[0]   <= v1_reg;
            sp_reg[0]   <= s1_reg;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                rhop_reg[i] <= rhop_reg[i-1];
                up_reg[i]   <= up_reg[i-1];
                vp_reg[i]   <= vp_reg[i-1];
                sp_reg[i]   <= sp_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
        begin
            case (WCLASS[k])
                W_REST:  rw_lane[k] = rw49_reg;
                W_AXIS:  rw_lane[k] = rw19_reg;
                W_DIAG:  rw_lane[k] = rw136_reg;
                default: rw_lane[k] = rw136_reg;
            endcase
        end
    end

    for (genvar k = 0; k < NDIR; k++)
    begin : g_lane
        d2q9_lane u_lane (
            .clk      (clk),
            .en       (en),
            .cx       (DIR_X[k]),
            .cy       (DIR_Y[k]),
            .u        (u1_reg),
            .v        (v1_reg),
            .f_in     (f1_reg[k]),
            .rw       (rw_lane[k]),
            .t1       (t1_reg),
            .omega    (relax_rate_reg),
            .lane_out (lane_res[k]),
            .f_out    (lane_f[k])
        );
    end

    // merge lanes and moments, solid nodes pass through
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sp_reg[LANE_LAT-1])
            begin
                out_reg  <= lane_f;
                dens_reg <= $signed({1'b0, ref_density_reg});
                vx_reg   <= '0;
                vy_reg   <= '0;
            end
            else
            begin
                out_reg  <= lane_res;
                dens_reg <= rhop_reg[LANE_LAT-1];
                vx_reg   <= up_reg[LANE_LAT-1];
                vy_reg   <= vp_reg[LANE_LAT-1];
            end
        end
    end

    assign res.out_rest      = out_reg[0];
    assign res.out_east      = out_reg[1];
    assign res.out_north     = out_reg[2];
    assign res.out_west      = out_reg[3];
    assign res.out_south     = out_reg[4];
    assign res.out_northeast = out_reg[5];
    assign res.out_northwest = out_reg[6];
    assign res.out_southwest = out_reg[7];
    assign res.out_southeast = out_reg[8];
    assign res.density       = dens_reg;
    assign res.vel_x         = vx_reg;
    assign res.vel_y         = vy_reg;

endmodule

@@ hw/rtl/d2q9_chk.sv @@
// ----------------------------------------------------------------------------
// d2q9 collision port checker
// Port-level properties of the collision block, bound to the top level.
// ----------------------------------------------------------------------------
module d2q9_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [d2q9_pkg::DATA_W-1:0] density,
    input logic signed [d2q9_pkg::DATA_W-1:0] vel_x,
    input logic signed [d2q9_pkg::DATA_W-1:0] vel_y
);
    import d2q9_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(density) && $stable(vel_x) && $stable(vel_y)))
        else $error("result changed while stalled");

    // a stalled result blocks new transfers
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");

    // no velocity without positive density
    a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (density <= 0)) |-> (vel_x == 0 && vel_y == 0))
        else $error("velocity on non-positive density");

endmodule

bind d2q9_bgk_collision d2q9_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (node.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .density   (res.density),
    .vel_x     (res.vel_x),
    .vel_y     (res.vel_y)
);
